FILE: rtl/thermocouple_trimmed_mean_filter_core_assert.svh
// assertion macros for the thermocouple trimmed mean filter core
// expects i_clk and i_rst_n in the scope of every use
`ifndef THERMOCOUPLE_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH
`define THERMOCOUPLE_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TTMF_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttmf same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TTMF_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttmf next-cycle check failed");

`endif

FILE: rtl/ttmf_pkg.sv
// shared types, codes and constants of the thermocouple trimmed mean filter
// no dependencies; used by every module of the block
package ttmf_pkg;

    // field widths
    localparam int TEMP_W  = 17;
    localparam int ADC_W   = 16;
    localparam int VREF_W  = 12;
    localparam int TIP_W   = 2;
    localparam int LIMIT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DEN_W   = 18;

    // temperatures in 1/16 degree
    localparam logic [TEMP_W-1:0] CLEAR_TEMP = 17'd480;
    localparam logic [TEMP_W-1:0] TEMP_MAX   = 17'd131071;

    // reading scale: 16000 / 128, the rest of the scale lives in the divisor
    localparam logic [6:0] SCALE_MUL = 7'd125;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    // register reset values
    localparam logic [TIP_W-1:0]   TIP_RESET   = 2'd0;
    localparam logic [VREF_W-1:0]  VREF_RESET  = 12'd3300;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8000;

    // tip codes
    localparam logic [TIP_W-1:0] TIP_T12    = 2'd0;
    localparam logic [TIP_W-1:0] TIP_JBC245 = 2'd1;
    localparam logic [TIP_W-1:0] TIP_JBC210 = 2'd2;

    // word operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // cell commands
    typedef logic [1:0] t_cell_cmd;
    localparam t_cell_cmd CELL_HOLD   = 2'd0;
    localparam t_cell_cmd CELL_REMOVE = 2'd1;
    localparam t_cell_cmd CELL_INSERT = 2'd2;

    typedef struct packed {
        logic              op;
        logic [ADC_W-1:0]  adc_value;
    } t_in_word;

    typedef struct packed {
        logic [TEMP_W-1:0] sample_temp;
        logic [TEMP_W-1:0] running_mean;
        logic [TEMP_W-1:0] trimmed_mean;
        logic              over_range;
    } t_out_word;

    // what one sorted cell shows its neighbors
    typedef struct packed {
        logic              hit;
        logic              vac;
        logic [TEMP_W-1:0] val;
    } t_cell_out;

    // divisor 4096 * 201 * D / 128 for tip constant D thousandths of mV
    function automatic logic [DEN_W-1:0] tip_den(input logic [TIP_W-1:0] tip);
        logic [DEN_W-1:0] d;
        case (tip)
            TIP_T12:    d = 18'd141504;
            TIP_JBC245: d = 18'd160800;
            TIP_JBC210: d = 18'd45024;
            default:    d = '0;
        endcase
        return d;
    endfunction

    // half of the divisor, for round to nearest
    function automatic logic [DEN_W-1:0] tip_bias(input logic [TIP_W-1:0] tip);
        logic [DEN_W-1:0] b;
        case (tip)
            TIP_T12:    b = 18'd70752;
            TIP_JBC245: b = 18'd80400;
            TIP_JBC210: b = 18'd22512;
            default:    b = '0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/ttmf_cell.sv
// one cell of the sorted temperature row: holds one value and a vacancy flag
// depends on ttmf_pkg; neighbors exchange t_cell_out every cycle
module ttmf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttmf_pkg::t_cell_cmd           i_cmd,
    input  logic [ttmf_pkg::TEMP_W-1:0]   i_key,
    input  ttmf_pkg::t_cell_out           i_below,
    input  ttmf_pkg::t_cell_out           i_above,
    output ttmf_pkg::t_cell_out           o_cell
);

    logic [ttmf_pkg::TEMP_W-1:0] r_val;
    logic [ttmf_pkg::TEMP_W-1:0] n_val;
    logic                        r_vac;
    logic                        n_vac;
    logic                        w_hit;

    // remove shifts the upper part down, insert shifts it up
    always_comb begin
        n_val = r_val;
        n_vac = r_vac;
        case (i_cmd)
            ttmf_pkg::CELL_REMOVE: begin
                w_hit = r_vac | (r_val >= i_key);
                if (w_hit) begin
                    n_val = i_above.val;
                    n_vac = i_above.vac;
                end
            end
            ttmf_pkg::CELL_INSERT: begin
                w_hit = r_vac | (r_val > i_key);
                if (w_hit) begin
                    if (i_below.hit) begin
                        n_val = i_below.val;
                        n_vac = i_below.vac;
                    end else begin
                        n_val = i_key;
                        n_vac = 1'b0;
                    end
                end
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= ttmf_pkg::CLEAR_TEMP;
            r_vac <= 1'b0;
        end else begin
            r_val <= n_val;
            r_vac <= n_vac;
        end
    end

    assign o_cell = '{hit: w_hit, vac: r_vac, val: r_val};

endmodule

FILE: rtl/ttmf_conv.sv
// reading to temperature conversion with a bit-serial rounding divider
// depends on ttmf_pkg; one quotient bit per cycle, saturates at the field maximum
module ttmf_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttmf_pkg::ADC_W-1:0]    i_adc,
    input  logic [ttmf_pkg::TIP_W-1:0]    i_tip,
    input  logic [ttmf_pkg::VREF_W-1:0]   i_vref,
    output logic                          o_done,
    output logic [ttmf_pkg::TEMP_W-1:0]   o_temp
);

    localparam int PROD_W = ttmf_pkg::VREF_W + ttmf_pkg::ADC_W;
    localparam int NUM_W  = 35;
    localparam int REM_W  = ttmf_pkg::DEN_W;
    localparam int QUO_W  = ttmf_pkg::TEMP_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_MUL   = 3'd1;
    localparam logic [2:0] C_SCALE = 3'd2;
    localparam logic [2:0] C_LOAD  = 3'd3;
    localparam logic [2:0] C_DIV   = 3'd4;

    logic [2:0]                   r_state;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_done;
    logic [ttmf_pkg::ADC_W-1:0]   r_adc;
    logic [PROD_W-1:0]            r_prod;
    logic [NUM_W-1:0]             r_num;
    logic [ttmf_pkg::DEN_W-1:0]   r_den;
    logic                         r_zero;
    logic [REM_W-1:0]             r_rem;
    logic [QUO_W-1:0]             r_quo;
    logic [ttmf_pkg::TEMP_W-1:0]  r_temp;
    logic [REM_W:0]               w_trial;
    logic [REM_W:0]               w_diff;
    logic                         w_ge;

    // one restoring division step
    always_comb begin
        w_trial = {r_rem, r_quo[QUO_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_state <= C_SCALE;
                end
                C_SCALE: begin
                    r_state <= C_LOAD;
                end
                C_LOAD: begin
                    if (r_zero || (r_num >= {r_den, {QUO_W{1'b0}}})) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_cnt   <= CNT_W'(QUO_W);
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_adc <= i_adc;
                end
            end
            C_MUL: begin
                r_prod <= i_vref * r_adc;
            end
            C_SCALE: begin
                r_num  <= NUM_W'(r_prod) * NUM_W'(ttmf_pkg::SCALE_MUL)
                          + NUM_W'(ttmf_pkg::tip_bias(i_tip));
                r_den  <= ttmf_pkg::tip_den(i_tip);
                r_zero <= (ttmf_pkg::tip_den(i_tip) == '0);
            end
            C_LOAD: begin
                if (r_zero) begin
                    r_temp <= '0;
                end else if (r_num >= {r_den, {QUO_W{1'b0}}}) begin
                    r_temp <= ttmf_pkg::TEMP_MAX;
                end
                r_rem <= r_num[NUM_W-1 -: REM_W];
                r_quo <= r_num[QUO_W-1:0];
            end
            C_DIV: begin
                r_rem <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                if (r_cnt == CNT_W'(1)) begin
                    r_temp <= {r_quo[QUO_W-2:0], w_ge};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_temp = r_temp;

endmodule

FILE: rtl/ttmf_cdiv.sv
// division of a sum by a fixed count: reciprocal multiply plus one correction
// depends on ttmf_pkg; two register stages, the estimate and the corrected quotient
module ttmf_cdiv #(
    parameter int IN_W    = 21,
    parameter int DIVISOR = 16
) (
    input  logic                          i_clk,
    input  logic [IN_W-1:0]               i_dividend,
    output logic [ttmf_pkg::TEMP_W-1:0]   o_quotient
);

    localparam int SH     = IN_W;
    localparam int M_W    = IN_W + 1;
    localparam int P_W    = IN_W + M_W;
    localparam int K_W    = $clog2(DIVISOR + 1);
    localparam int X_W    = IN_W + K_W;
    localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << SH) / DIVISOR);
    localparam logic [K_W-1:0] DIV_K = K_W'(DIVISOR);

    logic [P_W-1:0]                r_prod;
    logic [IN_W-1:0]               r_dvd;
    logic [ttmf_pkg::TEMP_W-1:0]   w_q0;
    logic [X_W-1:0]                w_back;
    logic [X_W-1:0]                w_rem;
    logic [ttmf_pkg::TEMP_W-1:0]   r_q;

    // estimate, low by at most one
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_dividend) * P_W'(RECIP);
        r_dvd  <= i_dividend;
    end

    // remainder check and correction
    always_comb begin
        w_q0   = r_prod[SH +: ttmf_pkg::TEMP_W];
        w_back = X_W'(w_q0) * X_W'(DIV_K);
        w_rem  = X_W'(r_dvd) - w_back;
    end

    always_ff @(posedge i_clk) begin
        r_q <= (w_rem >= X_W'(DIVISOR)) ? w_q0 + 1'b1 : w_q0;
    end

    assign o_quotient = r_q;

endmodule

FILE: rtl/thermocouple_trimmed_mean_filter_core.sv
// Thermocouple trimmed mean filter. Each input word either stores a reading
// (op 0) or only reports (op 1); every word gives one output word with the
// converted sample, the mean of the last RING_LENGTH temperatures and the mean
// with the TRIM_COUNT largest (at most RING_LENGTH - 1) left out. A stored
// reading passes the bit-serial conversion divider, the sorted cell row (remove
// the oldest, insert the new), the mean dividers, handshake and setup; the
// divider is skipped when the conversion saturates or the tip code is unused.
// A report-only or rejected reading skips the divider and the cell row. The
// output register lets a finished word wait for the sink. The user must write
// the registers only while no word is in flight; the block does not enforce it.
// depends on ttmf_pkg, ttmf_cell, ttmf_conv, ttmf_cdiv and the assertion header
`include "thermocouple_trimmed_mean_filter_core_assert.svh"

module thermocouple_trimmed_mean_filter_core #(
    parameter int RING_LENGTH = 16,
    parameter int TRIM_COUNT  = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ttmf_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ttmf_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [ttmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ttmf_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int TRIM_EFF = (TRIM_COUNT > RING_LENGTH - 1) ? RING_LENGTH - 1 : TRIM_COUNT;
    localparam int KEEP     = RING_LENGTH - TRIM_EFF;
    localparam int IDX_W    = $clog2(RING_LENGTH);
    localparam int SUM_W    = ttmf_pkg::TEMP_W + $clog2(RING_LENGTH);
    localparam int SUM_XW   = SUM_W + 1;
    localparam int TW       = ttmf_pkg::TEMP_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_REMOVE = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_MEAN0  = 3'd4;
    localparam logic [2:0] ST_MEAN1  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]                        r_state;
    logic [ttmf_pkg::TIP_W-1:0]        r_tip;
    logic [ttmf_pkg::VREF_W-1:0]       r_vref;
    logic [ttmf_pkg::LIMIT_W-1:0]      r_adc_limit;
    logic [IDX_W-1:0]                  r_widx;
    logic [SUM_W-1:0]                  r_ring_sum;
    logic [SUM_W-1:0]                  r_trim_sum;
    logic [RING_LENGTH-1:0]            r_ring_vld;
    logic [TW-1:0]                     r_ring_mem [RING_LENGTH];
    logic [TW-1:0]                     r_old;
    logic [TW-1:0]                     r_new;
    logic [TW-1:0]                     r_sample;
    logic                              r_over;
    logic                              r_out_valid;
    ttmf_pkg::t_out_word               r_out_word;

    logic                              w_in_acc;
    logic                              w_take;
    logic                              w_conv_done;
    logic [TW-1:0]                     w_conv_temp;
    logic                              w_out_load;
    ttmf_pkg::t_cell_cmd               w_cmd;
    logic [TW-1:0]                     w_key;
    ttmf_pkg::t_cell_out               w_chain [RING_LENGTH + 1];
    ttmf_pkg::t_cell_out               w_below [RING_LENGTH];
    logic [TW-1:0]                     w_run_mean;
    logic [TW-1:0]                     w_trim_mean;

    // handshake
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_take     = w_in_acc && (i_in_word.op == ttmf_pkg::OP_SAMPLE)
                        && (i_in_word.adc_value <= r_adc_limit);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tip       <= ttmf_pkg::TIP_RESET;
            r_vref      <= ttmf_pkg::VREF_RESET;
            r_adc_limit <= ttmf_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ttmf_pkg::CFG_TIP:   r_tip       <= i_cfg_data[ttmf_pkg::TIP_W-1:0];
                ttmf_pkg::CFG_VREF:  r_vref      <= i_cfg_data[ttmf_pkg::VREF_W-1:0];
                ttmf_pkg::CFG_LIMIT: r_adc_limit <= i_cfg_data[ttmf_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // conversion unit
    ttmf_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take),
        .i_adc   (i_in_word.adc_value),
        .i_tip   (r_tip),
        .i_vref  (r_vref),
        .o_done  (w_conv_done),
        .o_temp  (w_conv_temp)
    );

    // sorted cell row
    always_comb begin
        case (r_state)
            ST_REMOVE: w_cmd = ttmf_pkg::CELL_REMOVE;
            ST_INSERT: w_cmd = ttmf_pkg::CELL_INSERT;
            default:   w_cmd = ttmf_pkg::CELL_HOLD;
        endcase
        w_key = (r_state == ST_REMOVE) ? r_old : r_new;
    end

    assign w_chain[RING_LENGTH] = '{hit: 1'b1, vac: 1'b1, val: '0};

    for (genvar gi = 0; gi < RING_LENGTH; gi++) begin : g_cell
        if (gi == 0) begin : g_floor
            assign w_below[gi] = '{hit: 1'b0, vac: 1'b0, val: '0};
        end else begin : g_link
            assign w_below[gi] = w_chain[gi-1];
        end
        ttmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_key   (w_key),
            .i_below (w_below[gi]),
            .i_above (w_chain[gi+1]),
            .o_cell  (w_chain[gi])
        );
    end

    // temperature ring, unwritten entries read as the clear temperature
    always_ff @(posedge i_clk) begin
        if (r_state == ST_REMOVE) begin
            r_ring_mem[r_widx] <= r_new;
        end
        r_old <= r_ring_vld[r_widx] ? r_ring_mem[r_widx] : ttmf_pkg::CLEAR_TEMP;
    end

    // sequencer, sums and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_widx     <= '0;
            r_ring_vld <= '0;
            r_ring_sum <= SUM_W'(ttmf_pkg::CLEAR_TEMP * RING_LENGTH);
            r_trim_sum <= SUM_W'(ttmf_pkg::CLEAR_TEMP * KEEP);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_take ? ST_CONV : ST_MEAN0;
                    end
                end
                ST_CONV: begin
                    if (w_conv_done) begin
                        r_state <= ST_REMOVE;
                    end
                end
                ST_REMOVE: begin
                    r_ring_sum <= SUM_W'(SUM_XW'(r_ring_sum) + SUM_XW'(r_new)
                                         - SUM_XW'(r_old));
                    // oldest value sat in the kept part: the next one up slides in
                    if (w_chain[KEEP-1].hit) begin
                        r_trim_sum <= SUM_W'(SUM_XW'(r_trim_sum) + SUM_XW'(w_chain[KEEP].val)
                                             - SUM_XW'(r_old));
                    end
                    r_ring_vld[r_widx] <= 1'b1;
                    r_state <= ST_INSERT;
                end
                ST_INSERT: begin
                    // new value lands in the kept part: the top kept one drops out
                    if (w_chain[KEEP-1].hit) begin
                        r_trim_sum <= SUM_W'(SUM_XW'(r_trim_sum) + SUM_XW'(r_new)
                                             - SUM_XW'(w_chain[KEEP-1].val));
                    end
                    r_widx  <= (r_widx == IDX_W'(RING_LENGTH - 1)) ? '0 : r_widx + 1'b1;
                    r_state <= ST_MEAN0;
                end
                ST_MEAN0: begin
                    r_state <= ST_MEAN1;
                end
                ST_MEAN1: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // per word payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= '0;
            r_over   <= (i_in_word.op == ttmf_pkg::OP_SAMPLE)
                        && (i_in_word.adc_value > r_adc_limit);
        end else if (r_state == ST_REMOVE) begin
            r_sample <= r_new;
        end
        if ((r_state == ST_CONV) && w_conv_done) begin
            r_new <= w_conv_temp;
        end
    end

    // means
    ttmf_cdiv #(.IN_W(SUM_W), .DIVISOR(RING_LENGTH)) u_run_div (
        .i_clk      (i_clk),
        .i_dividend (r_ring_sum),
        .o_quotient (w_run_mean)
    );

    ttmf_cdiv #(.IN_W(SUM_W), .DIVISOR(KEEP)) u_trim_div (
        .i_clk      (i_clk),
        .i_dividend (r_trim_sum),
        .o_quotient (w_trim_mean)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word <= '{sample_temp:  r_sample,
                            running_mean: w_run_mean,
                            trimmed_mean: w_trim_mean,
                            over_range:   r_over};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    `TTMF_CHECK_NEXT(a_busy_after_accept, w_in_acc, !o_in_ready)
    `TTMF_CHECK_NOW(a_conv_done_in_conv, w_conv_done, r_state == ST_CONV)
    `TTMF_CHECK_NOW(a_trim_le_ring, r_state == ST_IDLE, r_trim_sum <= r_ring_sum)
    for (genvar gk = 0; gk < RING_LENGTH - 1; gk++) begin : g_chk
        `TTMF_CHECK_NOW(a_cells_sorted, r_state == ST_IDLE, !w_chain[gk].vac && (w_chain[gk].val <= w_chain[gk+1].val))
    end

endmodule

FILE: test/thermocouple_trimmed_mean_filter_core_tb.sv
// self-checking testbench for the thermocouple trimmed mean filter core
// depends on ttmf_pkg and the core; drives words, predicts each report, checks it
module thermocouple_trimmed_mean_filter_core_tb;
    import ttmf_pkg::*;

    localparam int RING_LEN    = 16;
    localparam int TRIM_LEN    = 5;
    localparam int KEEP_LEN    = RING_LEN - ((TRIM_LEN > RING_LEN - 1) ? RING_LEN - 1 : TRIM_LEN);
    localparam int SETTLE_CYC  = 40;
    localparam int QUIET_LIMIT = 3000;

    // register index past the end of the list, and the tip code with no constant
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [TIP_W-1:0]     TIP_UNUSED = 2'd3;

    // tip constants in thousandths of a millivolt per degree
    localparam longint unsigned MV_T12    = 22;
    localparam longint unsigned MV_JBC245 = 25;
    localparam longint unsigned MV_JBC210 = 7;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // filter state as seen by the predictor
    logic [TIP_W-1:0]   tip_reg;
    logic [VREF_W-1:0]  vref_reg;
    logic [LIMIT_W-1:0] limit_reg;
    int unsigned        temp_hist [RING_LEN];
    int unsigned        temp_sorted [RING_LEN];
    int unsigned        hist_total;
    int unsigned        hist_pos;

    t_out_word   reports_q [$];
    t_out_word   report_exp;
    int          errors      = 0;
    int          quiet_cycles = 0;
    int          ready_hold  = 0;
    bit          idle_on     = 1'b1;

    thermocouple_trimmed_mean_filter_core #(
        .RING_LENGTH(RING_LEN),
        .TRIM_COUNT (TRIM_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // convert, store and report one word; updates the predicted filter state
    function automatic t_out_word filter_predict(input t_in_word w);
        t_out_word       r;
        longint unsigned d, num, den, t;
        int unsigned     temp, old_v, kept_sum;
        int              p, i;
        bit              found;
        r = '0;
        if (w.op == OP_SAMPLE) begin
            if (w.adc_value > limit_reg) begin
                r.over_range = 1'b1;
            end else begin
                case (tip_reg)
                    TIP_T12:    d = MV_T12;
                    TIP_JBC245: d = MV_JBC245;
                    TIP_JBC210: d = MV_JBC210;
                    default:    d = 0;
                endcase
                if (d == 0) begin
                    temp = 0;
                end else begin
                    num = vref_reg;
                    num = num * w.adc_value * 16000;
                    den = 4096 * 201 * d;
                    t = (num + den / 2) / den;
                    temp = (t > TEMP_MAX) ? TEMP_MAX : t;
                end
                old_v = temp_hist[hist_pos];
                hist_total = hist_total - old_v + temp;
                temp_hist[hist_pos] = temp;
                // pull the oldest value out of the sorted copy
                p = RING_LEN - 1;
                found = 1'b0;
                for (i = 0; i < RING_LEN; i++) begin
                    if (!found && temp_sorted[i] == old_v) begin
                        p = i;
                        found = 1'b1;
                    end
                end
                for (i = p; i < RING_LEN - 1; i++)
                    temp_sorted[i] = temp_sorted[i + 1];
                // insertion from the top end
                i = RING_LEN - 1;
                while (i > 0 && temp_sorted[i - 1] > temp) begin
                    temp_sorted[i] = temp_sorted[i - 1];
                    i--;
                end
                temp_sorted[i] = temp;
                hist_pos = (hist_pos + 1) % RING_LEN;
                r.sample_temp = temp;
            end
        end
        r.running_mean = hist_total / RING_LEN;
        kept_sum = 0;
        for (i = 0; i < KEEP_LEN; i++)
            kept_sum += temp_sorted[i];
        r.trimmed_mean = kept_sum / KEEP_LEN;
        return r;
    endfunction

    // mostly in-range readings so the ring keeps moving, the rest anything
    function automatic t_in_word random_word();
        t_in_word w;
        w.op = ($urandom_range(0, 99) < 15) ? OP_QUERY : OP_SAMPLE;
        if ($urandom_range(0, 99) < 70)
            w.adc_value = $urandom_range(0, limit_reg);
        else
            w.adc_value = $urandom_range(0, 16'hFFFF);
        return w;
    endfunction

    // offer one word, optionally after a gap, and wait for it to be taken
    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 16)
            gap = $urandom_range(1, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        reports_q.push_back(filter_predict(w));
    endtask

    // stop offering and wait for every outstanding report
    task automatic wait_reports_drained(input int settle);
        i_in_valid <= 1'b0;
        while (reports_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIP:   tip_reg   = val[TIP_W-1:0];
            CFG_VREF:  vref_reg  = val[VREF_W-1:0];
            CFG_LIMIT: limit_reg = val[LIMIT_W-1:0];
            default:   ;
        endcase
        @(posedge i_clk);
    endtask

    // edges of the fields, each tip, and the special cases
    task automatic test_directed_cases();
        send_word('{op: OP_QUERY,  adc_value: 16'hFFFF});
        send_word('{op: OP_SAMPLE, adc_value: 16'd0});
        send_word('{op: OP_SAMPLE, adc_value: 16'd8000});
        send_word('{op: OP_SAMPLE, adc_value: 16'd8001});
        send_word('{op: OP_QUERY,  adc_value: 16'd0});
        wait_reports_drained(2);
        write_reg(CFG_LIMIT, 16'hFFFF);
        send_word('{op: OP_SAMPLE, adc_value: 16'hFFFF});
        send_word('{op: OP_SAMPLE, adc_value: 16'h8000});
        wait_reports_drained(2);
        write_reg(CFG_TIP, TIP_JBC245);
        send_word('{op: OP_SAMPLE, adc_value: 16'd4000});
        wait_reports_drained(2);
        write_reg(CFG_TIP, TIP_JBC210);
        send_word('{op: OP_SAMPLE, adc_value: 16'd4000});
        send_word('{op: OP_SAMPLE, adc_value: 16'd30000});
        wait_reports_drained(2);
        write_reg(CFG_TIP, TIP_UNUSED);
        send_word('{op: OP_SAMPLE, adc_value: 16'd4000});
        wait_reports_drained(2);
        write_reg(CFG_TIP, TIP_T12);
        write_reg(CFG_VREF, 16'd0);
        send_word('{op: OP_SAMPLE, adc_value: 16'd5000});
        wait_reports_drained(2);
        write_reg(CFG_VREF, 16'd4095);
        send_word('{op: OP_SAMPLE, adc_value: 16'd1234});
        wait_reports_drained(2);
        write_reg(CFG_LIMIT, 16'd0);
        send_word('{op: OP_SAMPLE, adc_value: 16'd0});
        send_word('{op: OP_SAMPLE, adc_value: 16'd1});
        wait_reports_drained(2);
        // write past the register list must change nothing
        write_reg(CFG_SPARE, 16'hFFFF);
        send_word('{op: OP_QUERY, adc_value: 16'h5A5A});
        wait_reports_drained(2);
        write_reg(CFG_VREF, 16'd1000);
        write_reg(CFG_LIMIT, 16'd8000);
    endtask

    // phases of random words, each under a fresh register setting
    task automatic test_random_phases(input int n_words);
        int sent, phase_len, pick;
        sent = 0;
        while (sent < n_words) begin
            wait_reports_drained(2);
            write_reg(CFG_TIP, ($urandom_range(0, 99) < 8) ? TIP_UNUSED
                                                            : $urandom_range(0, 2));
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(CFG_VREF, 16'd0);
                1:       write_reg(CFG_VREF, 16'd1000);
                2:       write_reg(CFG_VREF, 16'd4095);
                default: write_reg(CFG_VREF, $urandom_range(1000, 4095));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(CFG_LIMIT, 16'd0);
                1:       write_reg(CFG_LIMIT, 16'hFFFF);
                2, 3, 4: write_reg(CFG_LIMIT, 16'd8000);
                default: write_reg(CFG_LIMIT, $urandom_range(0, 16'hFFFF));
            endcase
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                send_word(random_word());
                // now and then let the pipe run dry before going on
                if ($urandom_range(0, 49) == 0)
                    wait_reports_drained(0);
            end
            sent += phase_len;
        end
    endtask

    // back to back words with the sink always ready
    task automatic test_no_idle_stretch(input int n_words);
        wait_reports_drained(0);
        idle_on <= 1'b0;
        repeat (n_words) send_word(random_word());
        wait_reports_drained(0);
        idle_on <= 1'b1;
    endtask

    // sink holds off while words keep coming, so the input backs up
    task automatic test_output_holdoff();
        wait_reports_drained(0);
        ready_hold <= 400;
        repeat (16) send_word(random_word());
        wait_reports_drained(0);
    endtask

    // sink side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else if (idle_on) begin
            i_out_ready <= ($urandom_range(0, 99) >= 16);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each report word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_q.size() == 0) begin
                $error("report word with nothing expected: %h", o_out_word);
                errors++;
            end else begin
                report_exp = reports_q.pop_front();
                if (o_out_word.sample_temp !== report_exp.sample_temp) begin
                    $error("sample_temp expected %0d actual %0d",
                           report_exp.sample_temp, o_out_word.sample_temp);
                    errors++;
                end
                if (o_out_word.running_mean !== report_exp.running_mean) begin
                    $error("running_mean expected %0d actual %0d",
                           report_exp.running_mean, o_out_word.running_mean);
                    errors++;
                end
                if (o_out_word.trimmed_mean !== report_exp.trimmed_mean) begin
                    $error("trimmed_mean expected %0d actual %0d",
                           report_exp.trimmed_mean, o_out_word.trimmed_mean);
                    errors++;
                end
                if (o_out_word.over_range !== report_exp.over_range) begin
                    $error("over_range expected %0d actual %0d",
                           report_exp.over_range, o_out_word.over_range);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        tip_reg    = TIP_RESET;
        vref_reg   = VREF_RESET;
        limit_reg  = LIMIT_RESET;
        for (int i = 0; i < RING_LEN; i++) begin
            temp_hist[i]   = CLEAR_TEMP;
            temp_sorted[i] = CLEAR_TEMP;
        end
        hist_total = CLEAR_TEMP * RING_LEN;
        hist_pos   = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_phases(1400);
        test_no_idle_stretch(400);
        test_output_holdoff();
        test_random_phases(200);

        wait_reports_drained(SETTLE_CYC);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
